// ===== src/imfiu_pkg.sv =====
`timescale 1ns / 1ps
package imfiu_pkg;

  // default sizing
  localparam int unsigned MapCapacity = 4096;
  localparam int unsigned BaseWidth   = 20;

  // fixed field widths
  localparam int unsigned IdWidth     = 64;
  localparam int unsigned KeyWidth    = 63;
  localparam int unsigned LimitWidth  = 13;
  localparam int unsigned OutIdxWidth = 12;
  localparam int unsigned SlotWidth   = 20;
  localparam int unsigned CountWidth  = 13;

  // status codes
  localparam logic [1:0] StOk      = 2'd0;
  localparam logic [1:0] StNegId   = 2'd1;
  localparam logic [1:0] StMapFull = 2'd2;

  localparam logic [LimitWidth-1:0] LimitReset = LimitWidth'(4096);

endpackage

// ===== src/imfiu_ram.sv =====
`timescale 1ns / 1ps
module imfiu_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  // one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

// ===== src/id_map_find_insert_unique.sv =====
`timescale 1ns / 1ps
// id_map_find_insert_unique
// Maps 64-bit ids to dense indices and tracks unique indices per table segment.
// Input channel: in_valid_i / in_stall_o with id_i, first_table_i, last_in_table_i.
// A beat is taken when valid is high and stall is low; stall is high while an
// item is being worked on. Output channel: out_valid_o / out_stall_i, one
// result beat per input beat, held in an output register so the next input
// can be taken while a result waits.
// A key lookup scans the key RAM one entry per cycle, so an item takes longer
// as next_index (indices handed out so far) grows; the seen check reads the
// position list only when needed. A negative id goes straight to finishing.
// The seen table needs no clearing: an entry counts only if its stored position
// is below the segment count and the position list points back at the index.
// Reset: asynchronous, active low; clears the index count, segment count, base
// and output valid; index_limit returns to 4096. The RAMs are not cleared.
// When the receiver stalls, the finished result is held and the next item
// waits in the finish state, keeping the input stalled. index_limit is written
// by cfg_we_i / cfg_wdata_i only while idle, a rule the block does not enforce.
module id_map_find_insert_unique #(
  parameter int unsigned MapCapacity = imfiu_pkg::MapCapacity,
  parameter int unsigned BaseWidth   = imfiu_pkg::BaseWidth
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   cfg_we_i,
  input  logic [imfiu_pkg::LimitWidth-1:0]       cfg_wdata_i,
  input  logic                                   in_valid_i,
  output logic                                   in_stall_o,
  input  logic signed [imfiu_pkg::IdWidth-1:0]   id_i,
  input  logic                                   first_table_i,
  input  logic                                   last_in_table_i,
  output logic                                   out_valid_o,
  input  logic                                   out_stall_i,
  output logic [imfiu_pkg::OutIdxWidth-1:0]      dense_index_o,
  output logic                                   first_in_table_o,
  output logic [imfiu_pkg::OutIdxWidth-1:0]      local_position_o,
  output logic [imfiu_pkg::SlotWidth-1:0]        unique_slot_o,
  output logic [imfiu_pkg::CountWidth-1:0]       table_unique_count_o,
  output logic [1:0]                             status_o,
  output logic                                   segment_done_o
);
  import imfiu_pkg::*;

  localparam int unsigned IW = $clog2(MapCapacity);
  localparam int unsigned CW = IW + 1;
  localparam int unsigned LW = (LimitWidth > CW) ? LimitWidth : CW;
  localparam int unsigned BW = BaseWidth;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_SCAN  = 3'd1;
  localparam logic [2:0] S_MISS  = 3'd2;
  localparam logic [2:0] S_SEEN1 = 3'd3;
  localparam logic [2:0] S_SEEN2 = 3'd4;
  localparam logic [2:0] S_SEEN3 = 3'd5;
  localparam logic [2:0] S_FIN   = 3'd6;

  logic [2:0]            state_q, state_d;
  logic [LimitWidth-1:0] limit_q;
  logic [CW-1:0]         next_q, next_d;
  logic [CW-1:0]         seg_q, seg_d;
  logic [BW-1:0]         base_q, base_d;
  logic [CW-1:0]         issue_q, issue_d;
  logic                  pend_q, pend_d;
  logic [IW-1:0]         pidx_q, pidx_d;
  logic [1:0]            err_q, err_d;
  logic                  fresh_q, fresh_d;
  logic [IW-1:0]         pos_q, pos_d;
  logic [KeyWidth-1:0]   key_q;
  logic                  first_q, last_q;

  logic                  ovalid_q;
  logic [OutIdxWidth-1:0] o_idx_q, o_pos_q;
  logic                  o_fresh_q, o_done_q;
  logic [SlotWidth-1:0]  o_slot_q;
  logic [CountWidth-1:0] o_cnt_q;
  logic [1:0]            o_st_q;

  // memory ports
  logic                  key_we, key_re;
  logic [IW-1:0]         key_raddr;
  logic [KeyWidth-1:0]   key_rdata;
  logic                  pos_we, pos_re;
  logic [IW-1:0]         pos_rdata;
  logic                  lst_we, lst_re;
  logic [IW-1:0]         lst_rdata;

  logic                  accept, out_free, fin_go;
  logic [BW-1:0]         base_sel;
  logic [CW-1:0]         cnt_new;
  logic [BW-1:0]         slot;
  logic                  full;

  assign accept   = in_valid_i && !in_stall_o;
  assign in_stall_o = (state_q != S_IDLE);
  assign out_free = !ovalid_q || !out_stall_i;
  assign fin_go   = (state_q == S_FIN) && out_free;
  assign full     = (LW'(next_q) >= LW'(limit_q)) || (next_q >= CW'(MapCapacity));

  // segment bookkeeping for the finishing item
  assign base_sel = first_q ? '0 : base_q;
  assign cnt_new  = seg_q + CW'(fresh_q);
  assign slot     = base_sel + BW'(pos_q);

  // sequencer
  always_comb begin
    state_d = state_q;
    next_d  = next_q;
    seg_d   = seg_q;
    base_d  = base_q;
    issue_d = issue_q;
    pend_d  = 1'b0;
    pidx_d  = pidx_q;
    err_d   = err_q;
    fresh_d = fresh_q;
    pos_d   = pos_q;
    key_re  = 1'b0;
    key_raddr = issue_q[IW-1:0];
    key_we  = 1'b0;
    pos_re  = 1'b0;
    pos_we  = 1'b0;
    lst_re  = 1'b0;
    lst_we  = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          issue_d = '0;
          fresh_d = 1'b0;
          if (id_i[IdWidth-1]) begin
            err_d   = StNegId;
            state_d = S_FIN;
          end else begin
            err_d   = StOk;
            state_d = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        // on a hit pidx_q already holds the matching entry
        if (pend_q && key_rdata == key_q) begin
          state_d = S_SEEN1;
        end else begin
          key_re  = issue_q < next_q;
          pend_d  = key_re;
          pidx_d  = issue_q[IW-1:0];
          issue_d = issue_q + CW'(1);
          if (!pend_q && !key_re) begin
            state_d = S_MISS;
          end
        end
      end
      S_MISS: begin
        if (full) begin
          err_d   = StMapFull;
          state_d = S_FIN;
        end else begin
          key_we  = 1'b1;
          pidx_d  = next_q[IW-1:0];
          next_d  = next_q + CW'(1);
          state_d = S_SEEN1;
        end
      end
      S_SEEN1: begin
        pos_re  = 1'b1;
        state_d = S_SEEN2;
      end
      S_SEEN2: begin
        pos_d = pos_rdata;
        if (CW'(pos_rdata) < seg_q) begin
          lst_re  = 1'b1;
          state_d = S_SEEN3;
        end else begin
          fresh_d = 1'b1;
          pos_d   = seg_q[IW-1:0];
          state_d = S_FIN;
        end
      end
      S_SEEN3: begin
        if (lst_rdata != pidx_q) begin
          fresh_d = 1'b1;
          pos_d   = seg_q[IW-1:0];
        end
        state_d = S_FIN;
      end
      S_FIN: begin
        if (out_free) begin
          state_d = S_IDLE;
          if (err_q == StOk) begin
            pos_we = fresh_q;
            lst_we = fresh_q;
            if (last_q) begin
              base_d = base_sel + BW'(cnt_new);
              seg_d  = '0;
            end else begin
              base_d = base_sel;
              seg_d  = cnt_new;
            end
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      limit_q <= LimitReset;
      next_q  <= '0;
      seg_q   <= '0;
      base_q  <= '0;
      pend_q  <= 1'b0;
      ovalid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      next_q  <= next_d;
      seg_q   <= seg_d;
      base_q  <= base_d;
      pend_q  <= pend_d;
      if (cfg_we_i) begin
        limit_q <= cfg_wdata_i;
      end
      if (fin_go) begin
        ovalid_q <= 1'b1;
      end else if (!out_stall_i) begin
        ovalid_q <= 1'b0;
      end
    end
  end

  // item and result payload
  always_ff @(posedge clk_i) begin
    issue_q <= issue_d;
    pidx_q  <= pidx_d;
    err_q   <= err_d;
    fresh_q <= fresh_d;
    pos_q   <= pos_d;
    if (accept) begin
      key_q   <= id_i[KeyWidth-1:0];
      first_q <= first_table_i;
      last_q  <= last_in_table_i;
    end
    if (fin_go) begin
      o_done_q <= last_q;
      o_st_q   <= err_q;
      if (err_q == StOk) begin
        o_idx_q   <= OutIdxWidth'(pidx_q);
        o_fresh_q <= fresh_q;
        o_pos_q   <= OutIdxWidth'(pos_q);
        o_slot_q  <= SlotWidth'(slot);
        o_cnt_q   <= last_q ? CountWidth'(cnt_new) : '0;
      end else begin
        o_idx_q   <= '0;
        o_fresh_q <= 1'b0;
        o_pos_q   <= '0;
        o_slot_q  <= '0;
        o_cnt_q   <= '0;
      end
    end
  end

  assign out_valid_o          = ovalid_q;
  assign dense_index_o        = o_idx_q;
  assign first_in_table_o     = o_fresh_q;
  assign local_position_o     = o_pos_q;
  assign unique_slot_o        = o_slot_q;
  assign table_unique_count_o = o_cnt_q;
  assign status_o             = o_st_q;
  assign segment_done_o       = o_done_q;

  // key store: dense index -> id
  imfiu_ram #(.Width(KeyWidth), .Depth(MapCapacity)) u_key_ram (
    .clk_i   (clk_i),
    .we_i    (key_we),
    .waddr_i (next_q[IW-1:0]),
    .wdata_i (key_q),
    .re_i    (key_re),
    .raddr_i (key_raddr),
    .rdata_o (key_rdata)
  );

  // seen positions: dense index -> first position in segment
  imfiu_ram #(.Width(IW), .Depth(MapCapacity)) u_pos_ram (
    .clk_i   (clk_i),
    .we_i    (pos_we),
    .waddr_i (pidx_q),
    .wdata_i (seg_q[IW-1:0]),
    .re_i    (pos_re),
    .raddr_i (pidx_q),
    .rdata_o (pos_rdata)
  );

  // position list: segment position -> dense index
  imfiu_ram #(.Width(IW), .Depth(MapCapacity)) u_lst_ram (
    .clk_i   (clk_i),
    .we_i    (lst_we),
    .waddr_i (seg_q[IW-1:0]),
    .wdata_i (pidx_q),
    .re_i    (lst_re),
    .raddr_i (pos_rdata),
    .rdata_o (lst_rdata)
  );

`ifndef SYNTHESIS
  a_next_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    next_q <= CW'(MapCapacity))
    else $error("index count above capacity");
  a_seg_le_next: assert property (@(posedge clk_i) disable iff (!rst_ni)
    seg_q <= next_q)
    else $error("segment count above handed-out indices");
  a_insert_inc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    key_we |=> next_q == $past(next_q) + CW'(1))
    else $error("insert did not advance index count");
  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && status_o != StOk) |-> (dense_index_o == '0 && !first_in_table_o))
    else $error("error beat carries data");
`endif

endmodule
